// ----- rtl/mvpi_pkg.sv -----
// Shared widths, register codes, constants and types of the multi-variant PI controller.
package mvpi_pkg;

    localparam int SIG_W    = 32;
    localparam int GAIN_W   = 32;
    localparam int MULX_W   = SIG_W + 1;
    localparam int ACC_W    = 48;
    localparam int GAIN_FRAC = 24;
    localparam int SIG_FRAC = 16;
    localparam int CFG_IDX_W = 3;
    localparam int VAR_W    = 3;

    localparam int INTEG_LIMIT_DEF = 100;

    localparam logic [VAR_W-1:0] VAR_PI       = 3'd0;
    localparam logic [VAR_W-1:0] VAR_TUSTIN   = 3'd1;
    localparam logic [VAR_W-1:0] VAR_PD       = 3'd2;
    localparam logic [VAR_W-1:0] VAR_SPEED_A  = 3'd3;
    localparam logic [VAR_W-1:0] VAR_SPEED_B  = 3'd4;
    localparam logic [VAR_W-1:0] VAR_SPEED_LP = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_VARIANT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANTIWINDUP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_COEFF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd7;

    localparam logic signed [GAIN_W-1:0] Q24_005 = 32'sd838861;
    localparam logic signed [GAIN_W-1:0] Q24_080 = 32'sd13421773;
    localparam logic signed [GAIN_W-1:0] Q24_020 = 32'sd3355443;
    localparam logic signed [SIG_W-1:0]  FIXED_OUT_LIM = 32'sd1310720;

    localparam logic [VAR_W-1:0]         RST_VARIANT    = VAR_PI;
    localparam logic                     RST_ANTIWINDUP = 1'b1;
    localparam logic signed [GAIN_W-1:0] RST_KP         = -32'sd654311;
    localparam logic signed [GAIN_W-1:0] RST_KI         = -32'sd21;
    localparam logic signed [GAIN_W-1:0] RST_KD         = 32'sd0;
    localparam logic signed [GAIN_W-1:0] RST_POS_COEFF  = 32'sd0;
    localparam logic signed [SIG_W-1:0]  RST_OUT_MAX    = 32'sd1966080;
    localparam logic signed [SIG_W-1:0]  RST_OUT_MIN    = -32'sd1966080;

    typedef struct packed {
        logic [VAR_W-1:0]         variant;
        logic                     antiwindup_enable;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [GAIN_W-1:0] position_coeff;
        logic signed [SIG_W-1:0]  out_max;
        logic signed [SIG_W-1:0]  out_min;
    } cfg_t;

    typedef struct packed {
        logic signed [SIG_W-1:0] drive_out;
        logic                    out_clamped;
        logic                    integ_clamped;
    } res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } seq_ctrl_t;

endpackage

// ----- rtl/mvpi_if.sv -----
// Valid/ready channel interfaces for the controller's sample input and drive output.
interface mvpi_sample_if import mvpi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SIG_W-1:0] reference;
    logic signed [SIG_W-1:0] feedback;
    logic signed [SIG_W-1:0] position_error;

    modport source (output valid, output reference, output feedback, output position_error,
                    input ready);
    modport sink (input valid, input reference, input feedback, input position_error,
                  output ready);
endinterface

interface mvpi_drive_if import mvpi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SIG_W-1:0] drive_out;
    logic                    out_clamped;
    logic                    integ_clamped;

    modport source (output valid, output drive_out, output out_clamped, output integ_clamped,
                    input ready);
    modport sink (input valid, input drive_out, input out_clamped, input integ_clamped,
                  output ready);
endinterface

// ----- rtl/multi_variant_pi_controller_unit.sv -----
// Top level of the multi-variant PI controller: configuration registers, handshakes, result register.
// A result not taken stalls the sequencer; the two-stage gain multiplier is used up to four times per
// item, and no new item is taken until the sequencer is idle, while a finished result may still wait.
// Reset (rst_n, asynchronous, active low) loads the register defaults and clears the integrator
// and last error; no clearing pass is needed.
module multi_variant_pi_controller_unit import mvpi_pkg::*;
#(
    parameter int INTEG_LIMIT = INTEG_LIMIT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [SIG_W-1:0]     wr_data,
    mvpi_sample_if.sink          sample,
    mvpi_drive_if.source         drive
);

    cfg_t      cfg_reg, cfg_next;
    res_t      res_reg, res_next;
    logic      out_valid_reg, out_valid_next;
    res_t      seq_res;
    seq_stat_t seq_stat;
    seq_ctrl_t seq_ctrl;

    assign seq_ctrl.out_free = !out_valid_reg || drive.ready;
    assign seq_ctrl.start    = sample.valid && seq_stat.idle;
    assign sample.ready      = seq_stat.idle;

    mvpi_seq #(
        .INTEG_LIMIT (INTEG_LIMIT)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .ctrl           (seq_ctrl),
        .reference      (sample.reference),
        .feedback       (sample.feedback),
        .position_error (sample.position_error),
        .stat           (seq_stat),
        .res            (seq_res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_VARIANT:    cfg_next.variant = wr_data[VAR_W-1:0];
                REG_ANTIWINDUP: cfg_next.antiwindup_enable = wr_data[0];
                REG_KP:         cfg_next.kp = wr_data;
                REG_KI:         cfg_next.ki = wr_data;
                REG_KD:         cfg_next.kd = wr_data;
                REG_POS_COEFF:  cfg_next.position_coeff = wr_data;
                REG_OUT_MAX:    cfg_next.out_max = wr_data;
                REG_OUT_MIN:    cfg_next.out_min = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (seq_stat.done)
        begin
            res_next       = seq_res;
            out_valid_next = 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.variant           <= RST_VARIANT;
            cfg_reg.antiwindup_enable <= RST_ANTIWINDUP;
            cfg_reg.kp                <= RST_KP;
            cfg_reg.ki                <= RST_KI;
            cfg_reg.kd                <= RST_KD;
            cfg_reg.position_coeff    <= RST_POS_COEFF;
            cfg_reg.out_max           <= RST_OUT_MAX;
            cfg_reg.out_min           <= RST_OUT_MIN;
            res_reg                   <= '0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign drive.valid         = out_valid_reg;
    assign drive.drive_out     = res_reg.drive_out;
    assign drive.out_clamped   = res_reg.out_clamped;
    assign drive.integ_clamped = res_reg.integ_clamped;

endmodule

// ----- rtl/mvpi_mulq.sv -----
// Shared two-stage gain multiplier: x times g over 2^24, rounded half away from zero.
module mvpi_mulq import mvpi_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MULX_W-1:0] x,
    input  logic signed [GAIN_W-1:0] g,
    output logic signed [ACC_W-1:0]  result
);

    localparam int PROD_W = 2 * GAIN_W;
    localparam int P_W    = PROD_W - GAIN_FRAC;

    logic [MULX_W-1:0]       ux;
    logic [GAIN_W-1:0]       ug;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       rnd;
    logic signed [ACC_W-1:0] mag;
    logic signed [ACC_W-1:0] result_next;
    logic signed [ACC_W-1:0] result_reg;

    always_comb
    begin
        ux = x[MULX_W-1] ? -x : x;
        ug = g[GAIN_W-1] ? -g : g;
        if (ux[MULX_W-1])
        begin
            prod = {ug, {GAIN_W{1'b0}}};
        end
        else
        begin
            prod = ux[MULX_W-2:0] * ug;
        end
    end

    always_comb
    begin
        rnd = prod_reg + (PROD_W'(1) << (GAIN_FRAC - 1));
        mag = {{(ACC_W-P_W){1'b0}}, rnd[PROD_W-1:GAIN_FRAC]};
        result_next = neg_reg ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod;
        neg_reg    <= x[MULX_W-1] ^ g[GAIN_W-1];
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- rtl/mvpi_seq.sv -----
// Sequencer and datapath that run one control law per item on the shared multiplier.
module mvpi_seq import mvpi_pkg::*;
#(
    parameter int INTEG_LIMIT = INTEG_LIMIT_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  seq_ctrl_t               ctrl,
    input  logic signed [SIG_W-1:0] reference,
    input  logic signed [SIG_W-1:0] feedback,
    input  logic signed [SIG_W-1:0] position_error,
    output seq_stat_t               stat,
    output res_t                    res
);

    localparam logic signed [ACC_W-1:0] LIM_A = ACC_W'(longint'(INTEG_LIMIT) << SIG_FRAC);
    localparam logic signed [ACC_W-1:0] NLIM_A = -LIM_A;
    localparam logic signed [SIG_W-1:0] LIM_S = LIM_A[SIG_W-1:0];
    localparam logic signed [SIG_W-1:0] NLIM_S = NLIM_A[SIG_W-1:0];

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_PRE2,
        ST_ERR,
        ST_ERR2,
        ST_MUL3,
        ST_MUL4,
        ST_SUM3,
        ST_SUM4,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [SIG_W-1:0] val;
        logic                    hit;
    } lim_t;

    function automatic logic signed [ACC_W-1:0] sx(input logic signed [SIG_W-1:0] v);
        return {{(ACC_W-SIG_W){v[SIG_W-1]}}, v};
    endfunction

    function automatic logic signed [MULX_W-1:0] mx(input logic signed [SIG_W-1:0] v);
        return {v[SIG_W-1], v};
    endfunction

    function automatic lim_t sat_sig(input logic signed [ACC_W-1:0] v);
        lim_t r;
        r.hit = !((&v[ACC_W-1:SIG_W-1]) || !(|v[ACC_W-1:SIG_W-1]));
        if (r.hit)
        begin
            r.val = v[ACC_W-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
        end
        else
        begin
            r.val = v[SIG_W-1:0];
        end
        return r;
    endfunction

    state_t                  state_reg, state_next;
    logic signed [SIG_W-1:0] ref_reg, ref_next;
    logic signed [SIG_W-1:0] fb_reg, fb_next;
    logic signed [SIG_W-1:0] pos_reg, pos_next;
    logic signed [ACC_W-1:0] diff_reg, diff_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [SIG_W-1:0] e_reg, e_next;
    logic signed [SIG_W-1:0] integ_reg, integ_next;
    logic signed [SIG_W-1:0] le_reg, le_next;
    logic                    ic_reg, ic_next;

    logic signed [MULX_W-1:0] mul_x;
    logic signed [GAIN_W-1:0] mul_g;
    logic signed [ACC_W-1:0]  mres;
    logic signed [ACC_W-1:0]  sat_in;
    lim_t                     sat_res;
    logic signed [ACC_W-1:0]  lim_in;
    lim_t                     lim_res;
    logic signed [SIG_W-1:0]  lo;
    logic signed [SIG_W-1:0]  hi;

    mvpi_mulq u_mulq (
        .clk    (clk),
        .x      (mul_x),
        .g      (mul_g),
        .result (mres)
    );

    assign sat_res = sat_sig(sat_in);

    always_comb
    begin
        if (cfg.antiwindup_enable)
        begin
            if (lim_in < NLIM_A)
            begin
                lim_res.val = NLIM_S;
                lim_res.hit = 1'b1;
            end
            else if (lim_in > LIM_A)
            begin
                lim_res.val = LIM_S;
                lim_res.hit = 1'b1;
            end
            else
            begin
                lim_res.val = lim_in[SIG_W-1:0];
                lim_res.hit = 1'b0;
            end
        end
        else
        begin
            lim_res = sat_sig(lim_in);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ref_next   = ref_reg;
        fb_next    = fb_reg;
        pos_next   = pos_reg;
        diff_next  = diff_reg;
        acc_next   = acc_reg;
        e_next     = e_reg;
        integ_next = integ_reg;
        le_next    = le_reg;
        ic_next    = ic_reg;
        mul_x      = '0;
        mul_g      = '0;
        sat_in     = diff_reg;
        lim_in     = '0;
        lo         = cfg.out_min;
        hi         = cfg.out_max;
        res        = '0;
        stat.idle  = 1'b0;
        stat.done  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (ctrl.start)
                begin
                    ref_next   = reference;
                    fb_next    = feedback;
                    pos_next   = position_error;
                    ic_next    = 1'b0;
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                unique case (cfg.variant)
                    VAR_PI:
                    begin
                        diff_next = sx(ref_reg) - sx(fb_reg);
                        mul_x = mx(le_reg);
                        mul_g = cfg.ki;
                    end
                    VAR_TUSTIN:
                    begin
                        diff_next = sx(ref_reg) - sx(fb_reg);
                        mul_x = mx(pos_reg);
                        mul_g = cfg.position_coeff;
                    end
                    VAR_PD:
                    begin
                        diff_next = sx(ref_reg) - sx(fb_reg);
                    end
                    VAR_SPEED_A:
                    begin
                        diff_next = sx(ref_reg) + sx(fb_reg);
                    end
                    VAR_SPEED_B:
                    begin
                        diff_next = sx(ref_reg) - sx(fb_reg);
                        mul_x = mx(pos_reg);
                        mul_g = Q24_005;
                    end
                    VAR_SPEED_LP:
                    begin
                        diff_next = sx(fb_reg) - sx(ref_reg);
                        mul_x = mx(le_reg);
                        mul_g = Q24_080;
                    end
                    default:
                    begin
                        diff_next = '0;
                    end
                endcase
                state_next = ST_PRE2;
            end
            ST_PRE2:
            begin
                if (cfg.variant == VAR_SPEED_LP)
                begin
                    mul_x = mx(sat_res.val);
                    mul_g = Q24_020;
                end
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                unique case (cfg.variant)
                    VAR_PI:
                    begin
                        e_next     = sat_res.val;
                        lim_in     = sx(integ_reg) + mres;
                        integ_next = lim_res.val;
                        ic_next    = lim_res.hit;
                    end
                    VAR_TUSTIN, VAR_SPEED_B:
                    begin
                        sat_in = diff_reg - mres;
                        e_next = sat_res.val;
                    end
                    VAR_PD, VAR_SPEED_A:
                    begin
                        e_next = sat_res.val;
                    end
                    VAR_SPEED_LP:
                    begin
                        acc_next = mres;
                    end
                    default:
                    begin
                        acc_next = '0;
                    end
                endcase
                state_next = ST_ERR2;
            end
            ST_ERR2:
            begin
                if (cfg.variant == VAR_SPEED_LP)
                begin
                    sat_in = acc_reg + mres;
                    e_next = sat_res.val;
                end
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                unique case (cfg.variant)
                    VAR_PI, VAR_PD:
                    begin
                        mul_x = mx(e_reg);
                        mul_g = cfg.kp;
                    end
                    VAR_TUSTIN, VAR_SPEED_B:
                    begin
                        mul_x = mx(e_reg) + mx(le_reg);
                        mul_g = cfg.ki;
                    end
                    VAR_SPEED_A:
                    begin
                        mul_x = mx(e_reg);
                        mul_g = cfg.ki;
                    end
                    VAR_SPEED_LP:
                    begin
                        mul_x      = mx(e_reg);
                        mul_g      = cfg.kp;
                        lim_in     = sx(integ_reg) + sx(e_reg);
                        integ_next = lim_res.val;
                        ic_next    = lim_res.hit;
                    end
                    default:
                    begin
                        mul_x = '0;
                    end
                endcase
                state_next = ST_MUL4;
            end
            ST_MUL4:
            begin
                unique case (cfg.variant)
                    VAR_TUSTIN, VAR_SPEED_A, VAR_SPEED_B:
                    begin
                        mul_x = mx(e_reg);
                        mul_g = cfg.kp;
                    end
                    VAR_PD:
                    begin
                        mul_x = mx(e_reg) - mx(le_reg);
                        mul_g = cfg.kd;
                    end
                    VAR_SPEED_LP:
                    begin
                        mul_x = mx(integ_reg);
                        mul_g = cfg.ki;
                    end
                    default:
                    begin
                        mul_x = '0;
                    end
                endcase
                state_next = ST_SUM3;
            end
            ST_SUM3:
            begin
                unique case (cfg.variant)
                    VAR_PI:
                    begin
                        acc_next = -mres - sx(integ_reg) - sx(pos_reg);
                    end
                    VAR_TUSTIN, VAR_SPEED_A:
                    begin
                        lim_in     = sx(integ_reg) + mres;
                        integ_next = lim_res.val;
                        ic_next    = lim_res.hit;
                    end
                    VAR_SPEED_B:
                    begin
                        lim_in     = mres;
                        integ_next = lim_res.val;
                        ic_next    = lim_res.hit;
                    end
                    VAR_PD, VAR_SPEED_LP:
                    begin
                        acc_next = mres;
                    end
                    default:
                    begin
                        acc_next = '0;
                    end
                endcase
                state_next = ST_SUM4;
            end
            ST_SUM4:
            begin
                unique case (cfg.variant)
                    VAR_TUSTIN, VAR_SPEED_B:
                    begin
                        acc_next = mres + sx(integ_reg);
                    end
                    VAR_PD, VAR_SPEED_LP:
                    begin
                        acc_next = acc_reg + mres;
                    end
                    VAR_SPEED_A:
                    begin
                        acc_next = -mres - sx(integ_reg);
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (cfg.variant == VAR_SPEED_B)
                begin
                    lo = -FIXED_OUT_LIM;
                    hi = FIXED_OUT_LIM;
                end
                if (cfg.variant <= VAR_SPEED_LP)
                begin
                    res.integ_clamped = ic_reg;
                    if (acc_reg < sx(lo))
                    begin
                        res.drive_out   = lo;
                        res.out_clamped = 1'b1;
                    end
                    else if (acc_reg > sx(hi))
                    begin
                        res.drive_out   = hi;
                        res.out_clamped = 1'b1;
                    end
                    else
                    begin
                        res.drive_out = acc_reg[SIG_W-1:0];
                    end
                end
                if (ctrl.out_free)
                begin
                    stat.done = 1'b1;
                    if (cfg.variant <= VAR_SPEED_LP && cfg.variant != VAR_SPEED_A)
                    begin
                        le_next = e_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ref_reg   <= '0;
            fb_reg    <= '0;
            pos_reg   <= '0;
            diff_reg  <= '0;
            acc_reg   <= '0;
            e_reg     <= '0;
            integ_reg <= '0;
            le_reg    <= '0;
            ic_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ref_reg   <= ref_next;
            fb_reg    <= fb_next;
            pos_reg   <= pos_next;
            diff_reg  <= diff_next;
            acc_reg   <= acc_next;
            e_reg     <= e_next;
            integ_reg <= integ_next;
            le_reg    <= le_next;
            ic_reg    <= ic_next;
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == ST_IDLE)
        else $error("item started while the sequencer was busy");

    a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && ctrl.out_free) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after its result");

    a_unused_variant_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && cfg.variant > VAR_SPEED_LP)
        |=> ($stable(integ_reg) && $stable(le_reg)))
        else $error("unused variant changed the controller state");

    a_pd_no_integ_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && cfg.variant == VAR_PD) |-> !ic_reg)
        else $error("PD law flagged an integrator clamp");

    a_antiwindup_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && ic_reg && cfg.antiwindup_enable)
        |-> (integ_reg == LIM_S || integ_reg == NLIM_S))
        else $error("integrator clamp flagged but integrator not at its limit");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the multi-variant PI controller: directed and random ticks, checked per field.
module tb;
    import mvpi_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_WAIT = 13;
    localparam int RANDOM_PHASES = 12;
    localparam int TICKS_PER_PHASE = 125;

    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint INTEG_SPAN = longint'(INTEG_LIMIT_DEF) * 65536;

    localparam logic [SIG_W-1:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [SIG_W-1:0] W_MIN = 32'h8000_0000;
    localparam logic [SIG_W-1:0] W_ZERO = 32'h0000_0000;

    localparam logic [VAR_W-1:0] VAR_SPARE_LO = 3'd6;
    localparam logic [VAR_W-1:0] VAR_SPARE_HI = 3'd7;
    localparam logic [VAR_W-1:0] LAW_ORDER [6] = '{VAR_PI, VAR_TUSTIN, VAR_PD,
                                                   VAR_SPEED_A, VAR_SPEED_B, VAR_SPEED_LP};

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [SIG_W-1:0] wr_data;

    mvpi_sample_if sample_ch();
    mvpi_drive_if drive_ch();

    cfg_t law_cfg;
    logic signed [SIG_W-1:0] integ_acc;
    logic signed [SIG_W-1:0] held_err;
    res_t pending_drive[$];
    res_t want_drive;
    int mismatch_count = 0;
    int cycle_count = 0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;

    multi_variant_pi_controller_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .sample(sample_ch),
        .drive(drive_ch)
    );

    always #1 clk = ~clk;

    function automatic longint widen(logic [SIG_W-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint bound(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint clip32(longint v);
        return bound(v, S32_LO, S32_HI);
    endfunction

    // Q16.16 times Q8.24, rounded to nearest with ties away from zero.
    function automatic longint gain_mul(longint x, longint g);
        bit neg;
        bit [63:0] mx;
        bit [63:0] mg;
        bit [63:0] prod;
        neg = (x < 0) != (g < 0);
        mx = (x < 0) ? -x : x;
        mg = (g < 0) ? -g : g;
        prod = (mx * mg + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
        return neg ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint wind_limit(longint v);
        if (law_cfg.antiwindup_enable)
            return bound(v, -INTEG_SPAN, INTEG_SPAN);
        return clip32(v);
    endfunction

    task automatic compute_drive(input logic [SIG_W-1:0] ref_w, input logic [SIG_W-1:0] fb_w,
                                 input logic [SIG_W-1:0] pos_w);
        longint r;
        longint f;
        longint p;
        longint e;
        longint u;
        longint kp;
        longint ki;
        longint kd;
        longint raw;
        longint lim;
        longint ov;
        longint oc;
        longint lo;
        longint hi;
        res_t res;
        r = widen(ref_w);
        f = widen(fb_w);
        p = widen(pos_w);
        kp = widen(law_cfg.kp);
        ki = widen(law_cfg.ki);
        kd = widen(law_cfg.kd);
        lo = widen(law_cfg.out_min);
        hi = widen(law_cfg.out_max);
        raw = widen(integ_acc);
        lim = raw;
        ov = 0;
        case (law_cfg.variant)
            VAR_PI:
            begin
                e = clip32(r - f);
                raw = widen(integ_acc) + gain_mul(widen(held_err), ki);
                lim = wind_limit(raw);
                ov = -gain_mul(e, kp) - lim - p;
                held_err = e[SIG_W-1:0];
            end
            VAR_TUSTIN:
            begin
                e = clip32(r - f - gain_mul(p, widen(law_cfg.position_coeff)));
                raw = widen(integ_acc) + gain_mul(e + widen(held_err), ki);
                lim = wind_limit(raw);
                ov = gain_mul(e, kp) + lim;
                held_err = e[SIG_W-1:0];
            end
            VAR_PD:
            begin
                e = clip32(r - f);
                ov = gain_mul(e, kp) + gain_mul(e - widen(held_err), kd);
                held_err = e[SIG_W-1:0];
            end
            VAR_SPEED_A:
            begin
                e = clip32(r + f);
                raw = widen(integ_acc) + gain_mul(e, ki);
                lim = wind_limit(raw);
                ov = -gain_mul(e, kp) - lim;
            end
            VAR_SPEED_B:
            begin
                e = clip32(r - f - gain_mul(p, widen(Q24_005)));
                raw = gain_mul(e + widen(held_err), ki);
                lim = wind_limit(raw);
                ov = gain_mul(e, kp) + lim;
                lo = -widen(FIXED_OUT_LIM);
                hi = widen(FIXED_OUT_LIM);
                held_err = e[SIG_W-1:0];
            end
            VAR_SPEED_LP:
            begin
                u = clip32(f - r);
                e = clip32(gain_mul(widen(held_err), widen(Q24_080)) + gain_mul(u, widen(Q24_020)));
                raw = widen(integ_acc) + e;
                lim = wind_limit(raw);
                ov = gain_mul(e, kp) + gain_mul(lim, ki);
                held_err = e[SIG_W-1:0];
            end
            default:
            begin
                lo = S32_LO;
                hi = S32_HI;
            end
        endcase
        integ_acc = lim[SIG_W-1:0];
        oc = bound(ov, lo, hi);
        res.drive_out = oc[SIG_W-1:0];
        res.out_clamped = (oc != ov);
        res.integ_clamped = (lim != raw);
        pending_drive.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input longint seen, input longint want);
        $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, seen, want,
                 cycle_count);
        mismatch_count++;
    endtask

    task automatic send_tick(input logic [SIG_W-1:0] ref_w, input logic [SIG_W-1:0] fb_w,
                             input logic [SIG_W-1:0] pos_w);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.reference = ref_w;
        sample_ch.feedback = fb_w;
        sample_ch.position_error = pos_w;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        compute_drive(ref_w, fb_w, pos_w);
    endtask

    task automatic settle();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIG_W-1:0] val);
        settle();
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        @(negedge clk);
        wr_en = 1'b0;
        case (idx)
            REG_VARIANT:    law_cfg.variant = val[VAR_W-1:0];
            REG_ANTIWINDUP: law_cfg.antiwindup_enable = val[0];
            REG_KP:         law_cfg.kp = val;
            REG_KI:         law_cfg.ki = val;
            REG_KD:         law_cfg.kd = val;
            REG_POS_COEFF:  law_cfg.position_coeff = val;
            REG_OUT_MAX:    law_cfg.out_max = val;
            REG_OUT_MIN:    law_cfg.out_min = val;
            default:        ;
        endcase
    endtask

    function automatic logic [SIG_W-1:0] random_signal();
        case ($urandom_range(0, 9))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return W_ZERO;
            3, 4, 5, 6, 7:
                     return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SIG_W-1:0] random_gain();
        case ($urandom_range(0, 7))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return W_ZERO;
            3, 4:    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            5, 6:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_state();
        send_tick(W_MAX, W_MIN, W_ZERO);
        send_tick(W_MIN, W_MAX, W_MAX);
        send_tick(W_ZERO, W_ZERO, W_MIN);
    endtask

    task automatic test_integrator_limits();
        cfg_write(REG_VARIANT, SIG_W'(VAR_SPEED_A));
        cfg_write(REG_KP, 32'h0100_0000);
        cfg_write(REG_KI, W_MAX);
        send_tick(W_MAX, W_MAX, W_ZERO);
        send_tick(W_MIN, W_MIN, W_ZERO);
        cfg_write(REG_ANTIWINDUP, SIG_W'(1'b0));
        send_tick(W_MAX, W_ZERO, W_ZERO);
        send_tick(W_MAX, W_ZERO, W_ZERO);
        send_tick(W_MIN, W_MIN, W_ZERO);
    endtask

    task automatic test_output_limits();
        cfg_write(REG_VARIANT, SIG_W'(VAR_PD));
        cfg_write(REG_KD, W_MIN);
        cfg_write(REG_OUT_MAX, W_MIN);
        cfg_write(REG_OUT_MIN, W_MAX);
        send_tick(32'h0001_0000, W_ZERO, W_ZERO);
        cfg_write(REG_OUT_MAX, W_MAX);
        cfg_write(REG_OUT_MIN, W_MIN);
        send_tick(W_MAX, W_MIN, W_ZERO);
        send_tick(W_MIN, W_MAX, W_ZERO);
    endtask

    task automatic test_each_variant();
        cfg_write(REG_ANTIWINDUP, SIG_W'(1'b1));
        cfg_write(REG_KP, 32'h0080_0000);
        cfg_write(REG_KI, 32'h0010_0000);
        cfg_write(REG_POS_COEFF, W_MIN);
        cfg_write(REG_OUT_MAX, 32'h0010_0000);
        cfg_write(REG_OUT_MIN, 32'hFFF0_0000);
        cfg_write(REG_VARIANT, SIG_W'(VAR_TUSTIN));
        send_tick(W_MAX, W_MIN, W_MAX);
        send_tick(32'h0001_8000, 32'h0000_4000, 32'hFFFF_0000);
        cfg_write(REG_VARIANT, SIG_W'(VAR_PI));
        send_tick(32'h0002_0000, 32'h0001_0000, 32'h0000_8000);
        send_tick(W_MIN, W_ZERO, W_MAX);
        cfg_write(REG_VARIANT, SIG_W'(VAR_SPEED_B));
        send_tick(W_MAX, W_ZERO, W_MIN);
        send_tick(32'h0000_C000, 32'h0001_0000, 32'h0003_0000);
        cfg_write(REG_VARIANT, SIG_W'(VAR_SPEED_LP));
        send_tick(W_MIN, W_MAX, W_ZERO);
        send_tick(32'h0001_0000, 32'h0002_0000, W_ZERO);
        cfg_write(REG_VARIANT, SIG_W'(VAR_SPARE_LO));
        send_tick(W_MAX, W_MIN, W_MAX);
        cfg_write(REG_VARIANT, SIG_W'(VAR_SPARE_HI));
        send_tick(W_MIN, W_MAX, W_MIN);
    endtask

    task automatic test_random_phases();
        logic [SIG_W-1:0] hold_ref;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if ($urandom_range(0, 7) == 0)
                cfg_write(REG_VARIANT,
                          SIG_W'($urandom_range(0, 1) ? VAR_SPARE_LO : VAR_SPARE_HI));
            else
                cfg_write(REG_VARIANT, SIG_W'(LAW_ORDER[ph % 6]));
            cfg_write(REG_ANTIWINDUP, $urandom_range(0, 1));
            cfg_write(REG_KP, random_gain());
            cfg_write(REG_KI, random_gain());
            cfg_write(REG_KD, random_gain());
            cfg_write(REG_POS_COEFF, random_gain());
            cfg_write(REG_OUT_MAX, ($urandom_range(0, 4) == 0) ? random_signal()
                                   : $urandom_range(0, 32'h0400_0000));
            cfg_write(REG_OUT_MIN, ($urandom_range(0, 4) == 0) ? random_signal()
                                   : 32'd0 - $urandom_range(0, 32'h0400_0000));
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            hold_ref = random_signal();
            for (int k = 0; k < TICKS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    hold_ref = random_signal();
                if ($urandom_range(0, 4) == 0)
                    send_tick(random_signal(), random_signal(), random_signal());
                else
                    send_tick(hold_ref,
                              hold_ref + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                              $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
            end
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    initial
    begin
        int stall;
        drive_ch.ready = 1'b0;
        forever
        begin
            stall = quiet_rx ? 0 : $urandom_range(0, MAX_WAIT);
            repeat (stall)
            begin
                @(negedge clk);
                drive_ch.ready = 1'b0;
            end
            @(negedge clk);
            drive_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!(rst_n && drive_ch.valid));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && drive_ch.valid && drive_ch.ready)
        begin
            if (pending_drive.size() == 0)
                report_mismatch("unexpected transfer", widen(drive_ch.drive_out), 0);
            else
            begin
                want_drive = pending_drive.pop_front();
                if (drive_ch.drive_out !== want_drive.drive_out)
                    report_mismatch("drive_out", widen(drive_ch.drive_out),
                                    widen(want_drive.drive_out));
                if (drive_ch.out_clamped !== want_drive.out_clamped)
                    report_mismatch("out_clamped", longint'(drive_ch.out_clamped),
                                    longint'(want_drive.out_clamped));
                if (drive_ch.integ_clamped !== want_drive.integ_clamped)
                    report_mismatch("integ_clamped", longint'(drive_ch.integ_clamped),
                                    longint'(want_drive.integ_clamped));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_VARIANT;
        wr_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.reference = '0;
        sample_ch.feedback = '0;
        sample_ch.position_error = '0;
        law_cfg = '{variant: RST_VARIANT, antiwindup_enable: RST_ANTIWINDUP, kp: RST_KP,
                    ki: RST_KI, kd: RST_KD, position_coeff: RST_POS_COEFF,
                    out_max: RST_OUT_MAX, out_min: RST_OUT_MIN};
        integ_acc = '0;
        held_err = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_state();
        test_integrator_limits();
        test_output_limits();
        test_each_variant();
        test_random_phases();
        settle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- multi_variant_pi_controller_unit.f -----
rtl/mvpi_pkg.sv
rtl/mvpi_if.sv
rtl/mvpi_mulq.sv
rtl/mvpi_seq.sv
rtl/multi_variant_pi_controller_unit.sv
tb/sv/tb.sv
